// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the jitter filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AJF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AJF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ajf_pkg.sv -----
// ----------------------------------------------------------------------------
// ajf_pkg
// Types and constants shared by the adaptive jitter filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ajf_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DRIFT_LIMIT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_SPREAD = 2'd2;

  localparam logic [6:0]  WINDOW_LENGTH_RST  = 7'd10;
  localparam logic [31:0] DRIFT_LIMIT_RST    = 32'd65536;
  localparam logic [31:0] INITIAL_SPREAD_RST = 32'd3277;

  localparam logic [31:0] ONE_Q16   = 32'd65536;
  localparam logic [31:0] RATIO_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [6:0]  window_length;
    logic [31:0] drift_limit;
    logic [31:0] initial_spread;
    logic        spread_load;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_AVG,
    S_PREV,
    S_RAVG,
    S_RFILT,
    S_RDRIFT,
    S_MUL,
    S_SPREAD,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/adaptive_jitter_filter.sv -----
// ----------------------------------------------------------------------------
// adaptive_jitter_filter
// Adaptive filter that suppresses jitter on a Q16.16 sensor value.
// ----------------------------------------------------------------------------
// One sample is taken at a time and one result is produced for it. A sample
// that settles at once (first in the window or zero) goes straight to the
// finish state. Any other sample is summed over the window one memory read per
// cycle and then passes through up to six divisions on a single bit-serial
// divider, one quotient bit per cycle, each division giving N = max(SAMPLE_BITS + 16,
// 33 + clog2(WINDOW_MAX + 1)) quotient bits. A finished result waits in the
// output register while the next sample is taken.
`default_nettype none

module adaptive_jitter_filter #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [ajf_pkg::ADDR_W-1:0]        paddr,
  input  wire  [ajf_pkg::DATA_W-1:0]        pwdata,
  output logic [ajf_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  signed [SAMPLE_BITS-1:0]     sample,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [31:0]                filtered,
  output logic                              changed
);
  import ajf_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int SUMW  = SB + CW;
  localparam int CMPW  = CW + 7;
  localparam int DIV_N = (SB + 16 > 33 + CW) ? SB + 16 : 33 + CW;
  localparam int DIV_D = SB;

  cfg_t cfg;

  state_t state, state_next;

  logic [AW-1:0]           head, head_nx;
  logic [CW-1:0]           count, count_nx;
  logic [CW:0]             count_inc;
  logic [CW-1:0]           w;
  logic [CMPW-1:0]         wl_ext;
  logic signed [SB-1:0]    cur, old_out, out_val, avg, prev;
  logic [31:0]             spread, r_avg, r_filt;
  logic signed [31:0]      drift;
  logic [32+CW-1:0]        prod;
  logic                    div_sent;

  logic                    accept, settle_now;
  logic signed [SUMW-1:0]  sum, diff;
  logic [SUMW-1:0]         sum_mag, diff_mag;
  logic                    sum_done;
  logic                    div_start, div_busy, div_done;
  logic [DIV_N-1:0]        div_a, div_q;
  logic [DIV_D-1:0]        div_b;
  logic [31:0]             q32, r_cur;
  logic signed [33:0]      cr;
  logic signed [34:0]      drift_sum;
  logic signed [31:0]      drift_sat;
  logic [31:0]             drift_mag;
  logic [SB-1:0]           cur_mag, avg_mag, prev_mag, out_mag;
  logic signed [SB-1:0]    q_signed;
  logic                    big_step, out_free;
  logic [63:0]             out_wide;

  ajf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ajf_hist #(
    .DEPTH  (WINDOW_MAX),
    .DATA_W (SB),
    .CNT_W  (CW)
  ) u_hist (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (accept),
    .wr_addr     (head_nx),
    .wr_data     (sample),
    .start       (accept && !settle_now),
    .start_head  (head_nx),
    .start_count (count_nx),
    .sum         (sum),
    .done        (sum_done)
  );

  ajf_div #(
    .N (DIV_N),
    .D (DIV_D)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Effective window: zero counts as one, anything above the memory depth saturates.
  assign wl_ext = CMPW'(cfg.window_length);
  always_comb begin
    if (wl_ext == '0) begin
      w = CW'(1);
    end else if (wl_ext > CMPW'(WINDOW_MAX)) begin
      w = CW'(WINDOW_MAX);
    end else begin
      w = CW'(wl_ext);
    end
  end

  assign head_nx   = (head == AW'(WINDOW_MAX - 1)) ? '0 : head + AW'(1);
  assign count_inc = (CW + 1)'(count) + (CW + 1)'(1);
  assign count_nx  = (count_inc > (CW + 1)'(w)) ? w : CW'(count_inc);

  assign accept     = in_valid && !in_stall;
  assign settle_now = (count_nx == CW'(1)) || (sample == '0);
  assign out_free   = !out_valid || !out_stall;

  assign diff     = sum - SUMW'({{CW{cur[SB-1]}}, cur});
  assign sum_mag  = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
  assign diff_mag = diff[SUMW-1] ? SUMW'(-diff) : SUMW'(diff);
  assign cur_mag  = cur[SB-1] ? SB'(-cur) : SB'(cur);
  assign avg_mag  = avg[SB-1] ? SB'(-avg) : SB'(avg);
  assign prev_mag = prev[SB-1] ? SB'(-prev) : SB'(prev);
  assign out_mag  = out_val[SB-1] ? SB'(-out_val) : SB'(out_val);

  // Quotient of a window average, with the sign restored (truncation toward zero).
  always_comb begin
    if (state == S_AVG ? sum[SUMW-1] : diff[SUMW-1]) begin
      q_signed = SB'(-div_q[SB-1:0]);
    end else begin
      q_signed = SB'(div_q[SB-1:0]);
    end
  end

  // Saturated Q16.16 ratio; a zero output as divisor saturates as well.
  always_comb begin
    if (div_q > DIV_N'(RATIO_MAX) || (state == S_RDRIFT && out_val == '0)) begin
      q32 = RATIO_MAX;
    end else begin
      q32 = div_q[31:0];
    end
  end

  assign cr    = $signed({2'b00, ONE_Q16}) - $signed({2'b00, q32});
  assign r_cur = (q32 >= ONE_Q16) ? q32 - ONE_Q16 : ONE_Q16 - q32;

  assign drift_sum = 35'(drift) + 35'(cr);
  always_comb begin
    if (drift_sum > 35'sd2147483647) begin
      drift_sat = 32'sh7FFF_FFFF;
    end else if (drift_sum < -35'sd2147483648) begin
      drift_sat = 32'sh8000_0000;
    end else begin
      drift_sat = drift_sum[31:0];
    end
  end
  assign drift_mag = drift_sat[31] ? 32'(-drift_sat) : 32'(drift_sat);

  assign big_step = {2'b00, r_avg} > ({2'b00, spread} + {1'b0, spread, 1'b0});

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = settle_now ? S_FIN : S_SUM;
      S_SUM:    if (sum_done) state_next = S_AVG;
      S_AVG:    if (div_done) state_next = S_PREV;
      S_PREV:   if (div_done) state_next = (div_q == '0) ? S_FIN : S_RAVG;
      S_RAVG:   if (div_done) state_next = S_RFILT;
      S_RFILT:  if (div_done) state_next = big_step ? S_MUL : S_RDRIFT;
      S_RDRIFT: if (div_done) state_next = S_MUL;
      S_MUL:    state_next = S_SPREAD;
      S_SPREAD: if (div_done) state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state != S_IDLE;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (state)
      S_AVG: begin
        div_start = !div_sent;
        div_a     = DIV_N'(sum_mag);
        div_b     = DIV_D'(count);
      end
      S_PREV: begin
        div_start = !div_sent;
        div_a     = DIV_N'(diff_mag);
        div_b     = DIV_D'(count - CW'(1));
      end
      S_RAVG: begin
        div_start = !div_sent;
        div_a     = DIV_N'({cur_mag, 16'd0});
        div_b     = prev_mag;
      end
      S_RFILT: begin
        div_start = !div_sent;
        div_a     = DIV_N'({avg_mag, 16'd0});
        div_b     = prev_mag;
      end
      S_RDRIFT: begin
        div_start = !div_sent;
        div_a     = DIV_N'({cur_mag, 16'd0});
        div_b     = out_mag;
      end
      S_SPREAD: begin
        div_start = !div_sent;
        div_a     = DIV_N'((33 + CW)'(prod) + (33 + CW)'(r_avg));
        div_b     = DIV_D'((CW + 1)'(w) + (CW + 1)'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      spread   <= INITIAL_SPREAD_RST;
      drift    <= '0;
      out_val  <= '0;
      div_sent <= 1'b0;
    end else begin
      if (cfg.spread_load) begin
        spread <= cfg.initial_spread;
      end
      if (div_start) begin
        div_sent <= 1'b1;
      end else if (div_done) begin
        div_sent <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            head  <= head_nx;
            count <= count_nx;
            if (count_nx == CW'(1)) begin
              out_val <= sample;
            end else if (sample == '0) begin
              out_val <= '0;
            end
          end
        end
        S_PREV: begin
          if (div_done && div_q == '0) begin
            out_val <= cur;
          end
        end
        S_RFILT: begin
          if (div_done && big_step) begin
            count <= CW'(1);
            drift <= '0;
            if (out_val != avg) begin
              out_val <= cur;
            end
          end
        end
        S_RDRIFT: begin
          if (div_done) begin
            if (r_filt > spread || drift_mag > cfg.drift_limit) begin
              drift   <= '0;
              out_val <= avg;
            end else begin
              drift <= drift_sat;
            end
          end
        end
        S_SPREAD: begin
          if (div_done) begin
            spread <= q32;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur     <= sample;
      old_out <= out_val;
    end
    if (div_done && state == S_AVG) begin
      avg <= q_signed;
    end
    if (div_done && state == S_PREV) begin
      prev <= q_signed;
    end
    if (div_done && state == S_RAVG) begin
      r_avg <= r_cur;
    end
    if (div_done && state == S_RFILT) begin
      r_filt <= r_cur;
    end
    if (state == S_MUL) begin
      prod <= (32 + CW)'(spread) * (32 + CW)'(w);
    end
  end

  assign out_wide = {{(64 - SB){out_val[SB-1]}}, out_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      filtered <= out_wide[31:0];
      changed  <= out_val != old_out;
    end
  end

  `include "assert_macros.svh"

  `AJF_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != S_IDLE, "transfer taken but filter stayed idle")
  `AJF_ASSERT_SAME(a_div_start_free, clk, rst, div_start, !div_busy, "divider started while busy")
  `AJF_ASSERT_SAME(a_count_bound, clk, rst, state != S_IDLE, count != '0 && count <= w, "window count out of range")
  `AJF_ASSERT_NEXT(a_result_loaded, clk, rst, state == S_FIN && out_free, out_valid && state == S_IDLE, "result not presented")

endmodule

`default_nettype wire

// ----- hdl/ajf_regs.sv -----
// ----------------------------------------------------------------------------
// ajf_regs
// Configuration registers behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
`default_nettype none

module ajf_regs (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [ajf_pkg::ADDR_W-1:0] paddr,
  input  wire  [ajf_pkg::DATA_W-1:0] pwdata,
  output logic [ajf_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ajf_pkg::cfg_t              cfg
);
  import ajf_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;
  logic [6:0]           window_length;
  logic [31:0]          drift_limit;
  logic [31:0]          initial_spread;
  logic                 spread_load;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= WINDOW_LENGTH_RST;
      drift_limit    <= DRIFT_LIMIT_RST;
      initial_spread <= INITIAL_SPREAD_RST;
      spread_load    <= 1'b0;
    end else begin
      spread_load <= 1'b0;
      if (wr) begin
        case (idx)
          REG_WINDOW_LENGTH:  window_length <= pwdata[6:0];
          REG_DRIFT_LIMIT:    drift_limit   <= pwdata;
          REG_INITIAL_SPREAD: begin
            initial_spread <= pwdata;
            spread_load    <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_WINDOW_LENGTH:  prdata = {25'd0, window_length};
      REG_DRIFT_LIMIT:    prdata = drift_limit;
      REG_INITIAL_SPREAD: prdata = initial_spread;
      default:            prdata = '0;
    endcase
  end

  assign cfg.window_length  = window_length;
  assign cfg.drift_limit    = drift_limit;
  assign cfg.initial_spread = initial_spread;
  assign cfg.spread_load    = spread_load;

endmodule

`default_nettype wire

// ----- hdl/ajf_div.sv -----
// ----------------------------------------------------------------------------
// ajf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ajf_div #(
  parameter int N = 48,
  parameter int D = 32
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          start,
  input  wire  [N-1:0] dividend,
  input  wire  [D-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [N-1:0] quotient
);
  import ajf_pkg::*;

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     dvd;
  logic [D-1:0]     dsr;
  logic [D-1:0]     rem;
  logic [CNT_W-1:0] cnt;
  logic [D:0]       trial;
  logic             fits;

  assign trial = {rem, dvd[N-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[N-2:0], 1'b0};
      rem      <= fits ? D'(trial - {1'b0, dsr}) : trial[D-1:0];
      quotient <= {quotient[N-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ajf_hist.sv -----
// ----------------------------------------------------------------------------
// ajf_hist
// Sample history memory with a serial window summer.
// ----------------------------------------------------------------------------
`default_nettype none

module ajf_hist #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32,
  parameter int CNT_W  = 7
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 wr_en,
  input  wire  [$clog2(DEPTH)-1:0]            wr_addr,
  input  wire  signed [DATA_W-1:0]            wr_data,
  input  wire                                 start,
  input  wire  [$clog2(DEPTH)-1:0]            start_head,
  input  wire  [CNT_W-1:0]                    start_count,
  output logic signed [DATA_W+CNT_W-1:0]      sum,
  output logic                                done
);
  import ajf_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int SUMW = DATA_W + CNT_W;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic [AW-1:0]            rd_addr;
  logic [CNT_W-1:0]         remaining;
  logic                     rd_valid;
  logic                     running;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // Walk backwards from the newest entry; the read data is registered, so it trails the read address.
  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      rd_valid  <= 1'b0;
      remaining <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running   <= 1'b1;
        rd_valid  <= 1'b0;
        remaining <= start_count;
      end else if (running) begin
        rd_valid <= remaining != '0;
        if (remaining != '0) begin
          remaining <= remaining - CNT_W'(1);
        end else if (!rd_valid) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_addr <= start_head;
      sum     <= '0;
    end else if (running) begin
      if (remaining != '0) begin
        rd_addr <= (rd_addr == '0) ? AW'(DEPTH - 1) : rd_addr - AW'(1);
      end
      if (rd_valid) begin
        sum <= sum + SUMW'({{CNT_W{rd_data[DATA_W-1]}}, rd_data});
      end
    end
  end

endmodule

`default_nettype wire
